>>> design/b2d_pkg.sv
// b2d_pkg: shared widths, constants and controller/datapath link types
// for the binary to decimal ASCII converter. No dependencies.
package b2d_pkg;

   localparam int VALUE_W      = 16;   // input value width
   localparam int DIGIT_W      = 6;    // ASCII digit code width
   localparam int BCD_DIGITS   = 5;    // decimal digits of a 16-bit value
   localparam int BCD_W        = 4;    // bits per BCD digit
   localparam int CNT_W        = $clog2(VALUE_W);
   localparam int IDX_W        = $clog2(BCD_DIGITS);
   localparam int MAX_DIGITS_DEF = 5;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 8;

   localparam logic [DIGIT_W-1:0] ASCII_ZERO = DIGIT_W'(48);
   localparam logic [BCD_W-1:0]   BCD_ADJ_MIN = BCD_W'(5);
   localparam logic [BCD_W-1:0]   BCD_ADJ     = BCD_W'(3);

   typedef struct packed {
      logic load;       // take a new value, clear the BCD register
      logic shift;      // one double dabble step
      logic set_count;  // latch index of the first digit to send
      logic emit;       // move current digit into the output register
   } cmd_type;

   typedef struct packed {
      logic conv_done;  // this shift is the last one
      logic last_idx;   // current digit is the least significant
      logic out_free;   // output register can take a digit this cycle
   } status_type;

endpackage

>>> design/b2d_ctrl.sv
// b2d_ctrl: sequencer for the converter (accept, convert, count, send).
// Depends on b2d_pkg.
module b2d_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  b2d_pkg::status_type  status,
   output b2d_pkg::cmd_type     cmd
);
   import b2d_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CONV  = 2'd1;
   localparam logic [1:0] ST_COUNT = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_tready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            if (req_tvalid) state_in = ST_CONV;
         end
         ST_CONV: begin
            cmd.shift = 1'b1;
            if (status.conv_done) state_in = ST_COUNT;
         end
         ST_COUNT: begin
            cmd.set_count = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
            if (status.out_free && status.last_idx) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> design/b2d_dp.sv
// b2d_dp: bit-serial double dabble datapath, digit selector and output register.
// Depends on b2d_pkg.
module b2d_dp #(
   parameter int MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [b2d_pkg::VALUE_W-1:0]    value,
   input  b2d_pkg::cmd_type               cmd,
   output b2d_pkg::status_type            status,
   input  logic                           out_ready,
   output logic                           out_valid,
   output logic [b2d_pkg::DIGIT_W-1:0]    digit_char,
   output logic                           last_digit
);
   import b2d_pkg::*;

   // digits beyond this many are dropped (only reachable for small MAX_DIGITS)
   localparam int LIMIT = (MAX_DIGITS < 1) ? 1 :
                          (MAX_DIGITS < BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;

   logic [VALUE_W-1:0]                   bin_ff, bin_in;
   logic [BCD_DIGITS-1:0][BCD_W-1:0]     bcd_ff, bcd_in;
   logic [BCD_DIGITS-1:0][BCD_W-1:0]     bcd_adj;
   logic [BCD_DIGITS*BCD_W-1:0]          bcd_adj_bits;
   logic [CNT_W-1:0]                     cnt_ff, cnt_in;
   logic [IDX_W-1:0]                     idx_ff, idx_in;
   logic [IDX_W-1:0]                     top_idx;
   logic                                 out_valid_ff, out_valid_in;
   logic [DIGIT_W-1:0]                   digit_ff, digit_in;
   logic                                 last_ff, last_in;

   // add 3 to every digit of 5 or more ahead of the shift
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= BCD_ADJ_MIN) ? bcd_ff[i] + BCD_ADJ : bcd_ff[i];
      end
   end

   assign bcd_adj_bits = bcd_adj;

   // most significant nonzero digit, capped at LIMIT - 1; zero gives digit 0
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[i] != '0) top_idx = IDX_W'(i);
      end
      if (top_idx > IDX_W'(LIMIT - 1)) top_idx = IDX_W'(LIMIT - 1);
   end

   always_comb begin
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      digit_in     = digit_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff;
      if (out_ready) out_valid_in = 1'b0;
      if (cmd.load) begin
         bin_in = value;
         bcd_in = '0;
         cnt_in = '0;
      end
      if (cmd.shift) begin
         bcd_in = {bcd_adj_bits[BCD_DIGITS*BCD_W-2:0], bin_ff[VALUE_W-1]};
         bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.set_count) idx_in = top_idx;
      if (cmd.emit) begin
         digit_in     = ASCII_ZERO + DIGIT_W'(bcd_ff[idx_ff]);
         last_in      = (idx_ff == '0);
         idx_in       = idx_ff - IDX_W'(1);
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      digit_ff <= digit_in;
      last_ff  <= last_in;
   end

   // the sequencer looks at this only while shifting
   assign status.conv_done = (cnt_ff == CNT_W'(VALUE_W - 1));
   assign status.last_idx  = (idx_ff == '0);
   assign status.out_free  = !out_valid_ff || out_ready;

   assign out_valid  = out_valid_ff;
   assign digit_char = digit_ff;
   assign last_digit = last_ff;

endmodule

>>> design/binary_to_decimal_ascii.sv
// Operation: an accept step, 16 double dabble shifts and a count step, then
// the digits go out through the output register, most significant first.
// A new value is taken only once the last digit has entered the output
// register, and a stalled sink holds the sequencer; the bit-serial shift
// loop over 16 input bits sets the pace.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// any digit waiting in the output register.
module binary_to_decimal_ascii #(
   parameter int MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream: one value per transfer
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [b2d_pkg::REQ_DATA_W-1:0]     req_tdata,   // [15:0] value
   // response stream: one ASCII digit per transfer, most significant first
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [b2d_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [5:0] digit_char, [7:6] zero
   output logic                               rsp_tlast    // last_digit
);
   import b2d_pkg::*;

   cmd_type             cmd;
   status_type          status;
   logic [DIGIT_W-1:0]  digit_char;

   // sequencer: idle -> shift 16 times -> pick first digit -> send digits
   b2d_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // shift register, BCD digits and the output register; the output register
   // lets the last digit wait while the next value is already taken
   b2d_dp #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .value      (req_tdata[VALUE_W-1:0]),
      .cmd        (cmd),
      .status     (status),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .digit_char (digit_char),
      .last_digit (rsp_tlast)
   );

   // pad the digit code up to a whole byte
   assign rsp_tdata = {{(RSP_DATA_W - DIGIT_W){1'b0}}, digit_char};

endmodule

>>> design/b2d_checker.sv
// b2d_checker: port-level checks on the converter, bound to the top level.
// Depends on b2d_pkg and binary_to_decimal_ascii.
module b2d_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [b2d_pkg::REQ_DATA_W-1:0]   req_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [b2d_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                             rsp_tlast
);
   import b2d_pkg::*;

   // a stalled digit holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // every digit is an ASCII decimal code
   a_rsp_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >= RSP_DATA_W'(ASCII_ZERO)) &&
                     (rsp_tdata <= RSP_DATA_W'(ASCII_ZERO) + RSP_DATA_W'(9)))
      else $error("response is not a decimal digit");

   // one value at a time: busy after a transfer in
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while converting");

   // a value taken while no digit is waiting gives no digit early in its conversion
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> ##1 !rsp_tvalid)
      else $error("digit appeared during conversion");

endmodule

bind binary_to_decimal_ascii b2d_checker u_b2d_checker (.*);

>>> dv/tb_binary_to_decimal_ascii.sv
// Self-checking testbench for binary_to_decimal_ascii: drives 16-bit values, predicts
// the ASCII decimal digit stream of each one and checks every response transfer.
// Depends on b2d_pkg and the binary_to_decimal_ascii RTL only.
`timescale 1ns / 100ps

module tb_binary_to_decimal_ascii;
   import b2d_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int RESET_CYCLES = 10;
   localparam int RADIX        = 10;
   localparam int DIGIT_CAP    = 20;
   localparam int RANDOM_ITEMS = 410;
   localparam int MAX_WAIT     = 7;
   localparam int DRAIN_CYCLES = 40;

   // one expected response transfer
   typedef struct packed {
      logic [DIGIT_W-1:0] digit_char;
      logic               last_digit;
   } ascii_digit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [15:0] value
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [5:0] digit_char, [7:6] zero
   logic                  rsp_tlast;         // last_digit

   logic [VALUE_W-1:0] pending_values[$];   // values not yet offered to the block
   ascii_digit_type    expected_digits[$];  // digits still owed by the block

   int unsigned mismatches  = 0;
   int unsigned req_wait    = 0;
   int unsigned rsp_wait    = 0;
   bit          req_no_idle = 1'b0;
   bit          rsp_no_idle = 1'b0;

   binary_to_decimal_ascii dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatches++;
   endtask

   // Split a value into decimal digits, least significant first, then queue them
   // most significant first. Only the lowest digit carries the end-of-run flag.
   function automatic void queue_decimal_digits(input logic [VALUE_W-1:0] value);
      logic [BCD_W-1:0] digits[DIGIT_CAP];
      int unsigned      rest;
      int unsigned      count;
      int unsigned      limit;
      ascii_digit_type  entry;
      limit = MAX_DIGITS_DEF;
      if (limit < 1) limit = 1;
      if (limit > DIGIT_CAP) limit = DIGIT_CAP;
      rest  = value;
      count = 0;
      do begin
         digits[count] = BCD_W'(rest % RADIX);
         count++;
         rest = rest / RADIX;
      end while (rest != 0 && count < limit);
      for (int k = int'(count) - 1; k >= 0; k--) begin
         entry.digit_char = ASCII_ZERO + DIGIT_W'(digits[k]);
         entry.last_digit = (k == 0);
         expected_digits.push_back(entry);
      end
   endfunction

   // Draw the idle cycles before the next transfer; a side in a no-idle stretch
   // draws zero, and the stretch flips now and then so both kinds of run occur.
   function automatic int unsigned draw_wait(inout bit no_idle);
      if ($urandom_range(0, 19) == 0) no_idle = ~no_idle;
      return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // Request driver: predict on every accepted value, then either hold the
   // current item, idle for the drawn gap, or present the next pending value.
   // req_tvalid is assigned at most once per edge and is left as it is while an item is held.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_wait   = draw_wait(req_no_idle);
      end else begin
         if (req_tvalid && req_tready) begin
            queue_decimal_digits(req_tdata[VALUE_W-1:0]);
            req_wait = draw_wait(req_no_idle);
         end
         if (!req_tvalid || req_tready) begin
            if (req_wait > 0) begin
               req_wait--;
               req_tvalid <= 1'b0;
            end else if (pending_values.size() > 0) begin
               req_tdata  <= pending_values.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compare each transfer with the oldest expected digit,
   // then stall for the drawn number of cycles before taking the next one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   = draw_wait(rsp_no_idle);
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_digits.size() == 0) begin
               report_mismatch($sformatf("unexpected digit tdata=0x%02h tlast=%0b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               ascii_digit_type want;
               want = expected_digits.pop_front();
               if (rsp_tdata !== RSP_DATA_W'(want.digit_char))
                  report_mismatch($sformatf("digit_char got 0x%02h, want 0x%02h",
                                            rsp_tdata, want.digit_char));
               if (rsp_tlast !== want.last_digit)
                  report_mismatch($sformatf("last_digit got %0b, want %0b",
                                            rsp_tlast, want.last_digit));
            end
            rsp_wait = draw_wait(rsp_no_idle);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus and end of test.
   initial begin
      logic [VALUE_W-1:0] directed[];
      int unsigned n_digits;
      int unsigned lo;
      int unsigned hi;

      directed = '{
         16'd0, 16'd1, 16'd7, 16'd9, 16'd10, 16'd99, 16'd100, 16'd255, 16'd999,
         16'd1000, 16'd4096, 16'd9999, 16'd10000, 16'd10009, 16'd12345, 16'd32768,
         16'h5555, 16'hAAAA, 16'd50000, 16'd59999, 16'd60000, 16'd65534, 16'd65535
      };

      // directed: digit-count boundaries, zero, all-ones and alternating bits
      foreach (directed[i]) pending_values.push_back(directed[i]);

      // random: spread evenly over one to five digits, plus some raw 16-bit values
      repeat (RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            pending_values.push_back(VALUE_W'($urandom()));
         end else begin
            n_digits = $urandom_range(1, BCD_DIGITS);
            lo = (n_digits == 1) ? 0 : RADIX ** (n_digits - 1);
            hi = (n_digits == BCD_DIGITS) ? 65535 : RADIX ** n_digits - 1;
            pending_values.push_back(VALUE_W'($urandom_range(lo, hi)));
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // hold until every value is accepted and every digit has come back
      while (pending_values.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_digits.size() > 0) @(posedge clock);
      // watch a little longer for stray digits
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_digits.size() == 0) begin
         $display("binary_to_decimal_ascii test passed");
      end else begin
         $display("binary_to_decimal_ascii test failed");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run.
   initial begin
      #2ms;
      $display("binary_to_decimal_ascii test failed");
      $finish;
   end

endmodule
